/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files of the xorwow generator.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/xorwow_pkg.sv */
// Shared types, codes and constants of the xorwow generator.
// Used by xorwow_ctrl, xorwow_dp and the top level; depends on nothing.
package xorwow_pkg;

	localparam int NUM_WORDS = 5;
	localparam int IDX_W     = $clog2(NUM_WORDS);
	localparam int CFG_IDX_W = 2;

	// Operation codes carried on tuser
	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_RESEED   = 1'b1;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_THIRD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEYL_INC     = 2'd3;

	localparam logic [4:0]  RST_SHIFT_FIRST  = 5'd2;
	localparam logic [4:0]  RST_SHIFT_SECOND = 5'd1;
	localparam logic [4:0]  RST_SHIFT_THIRD  = 5'd4;
	localparam logic [31:0] RST_WEYL_INC     = 32'd362437;
	localparam logic [31:0] COUNTER_START    = 32'd6615241;

	// Finaliser multipliers
	localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

	// Datapath commands
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_GEN,
		DP_DEFAULT,
		DP_SEED,
		DP_LOAD,
		DP_MUL_LL,
		DP_MUL_HL,
		DP_MUL_LH,
		DP_MIX,
		DP_STORE,
		DP_FIX
	} dp_op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_LL,
		ST_MUL_HL,
		ST_MUL_LH,
		ST_MIX,
		ST_STORE,
		ST_FIX
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t           op;
		logic             round;     // 0: first multiplier, 1: second
		logic [IDX_W-1:0] word_idx;  // word being hashed
	} dp_cmd_t;

	typedef struct packed {
		logic seed_zero;
	} dp_status_t;

	function automatic logic [31:0] default_word(input logic [IDX_W-1:0] idx);
		logic [31:0] w;
		case (idx)
			3'd0:    w = 32'd123456789;
			3'd1:    w = 32'd362436069;
			3'd2:    w = 32'd521288629;
			3'd3:    w = 32'd88675123;
			3'd4:    w = 32'd5783321;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

	function automatic logic [63:0] seed_mask(input logic [IDX_W-1:0] idx);
		logic [63:0] m;
		case (idx)
			3'd1:    m = 64'h5555555555555555;
			3'd2:    m = 64'h0AAAAAAAAAAAAAAA;
			3'd3:    m = 64'h0123456789ABCDEF;
			3'd4:    m = 64'h0FEDCBA987654321;
			default: m = 64'h0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/xorwow_ctrl.sv */
// Controller of the xorwow generator: handshakes and the reseed sequencer.
// Depends on xorwow_pkg; drives xorwow_dp through a command struct.
module xorwow_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_op,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  xorwow_pkg::dp_status_t status,
	output xorwow_pkg::dp_cmd_t    cmd
);

	xorwow_pkg::ctrl_state_t            state_q, state_d;
	logic                               round_q;
	logic [xorwow_pkg::IDX_W-1:0]       idx_q;
	logic                               out_valid_q;
	logic                               accept;
	logic                               last_word;

	assign in_ready  = (state_q == xorwow_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign last_word = (idx_q == xorwow_pkg::IDX_W'(xorwow_pkg::NUM_WORDS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xorwow_pkg::ST_IDLE: begin
				if (accept && (in_op == xorwow_pkg::OP_RESEED) && !status.seed_zero)
					state_d = xorwow_pkg::ST_LOAD;
			end
			xorwow_pkg::ST_LOAD:   state_d = xorwow_pkg::ST_MUL_LL;
			xorwow_pkg::ST_MUL_LL: state_d = xorwow_pkg::ST_MUL_HL;
			xorwow_pkg::ST_MUL_HL: state_d = xorwow_pkg::ST_MUL_LH;
			xorwow_pkg::ST_MUL_LH: begin
				state_d = round_q ? xorwow_pkg::ST_STORE : xorwow_pkg::ST_MIX;
			end
			xorwow_pkg::ST_MIX:    state_d = xorwow_pkg::ST_MUL_LL;
			xorwow_pkg::ST_STORE: begin
				state_d = last_word ? xorwow_pkg::ST_FIX : xorwow_pkg::ST_LOAD;
			end
			xorwow_pkg::ST_FIX:    state_d = xorwow_pkg::ST_IDLE;
			default:               state_d = xorwow_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd.op       = xorwow_pkg::DP_IDLE;
		cmd.round    = round_q;
		cmd.word_idx = idx_q;
		case (state_q)
			xorwow_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_op == xorwow_pkg::OP_GENERATE)
						cmd.op = xorwow_pkg::DP_GEN;
					else if (status.seed_zero)
						cmd.op = xorwow_pkg::DP_DEFAULT;
					else
						cmd.op = xorwow_pkg::DP_SEED;
				end
			end
			xorwow_pkg::ST_LOAD:   cmd.op = xorwow_pkg::DP_LOAD;
			xorwow_pkg::ST_MUL_LL: cmd.op = xorwow_pkg::DP_MUL_LL;
			xorwow_pkg::ST_MUL_HL: cmd.op = xorwow_pkg::DP_MUL_HL;
			xorwow_pkg::ST_MUL_LH: cmd.op = xorwow_pkg::DP_MUL_LH;
			xorwow_pkg::ST_MIX:    cmd.op = xorwow_pkg::DP_MIX;
			xorwow_pkg::ST_STORE:  cmd.op = xorwow_pkg::DP_STORE;
			xorwow_pkg::ST_FIX:    cmd.op = xorwow_pkg::DP_FIX;
			default:               cmd.op = xorwow_pkg::DP_IDLE;
		endcase
	end

	// State, word index, round and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xorwow_pkg::ST_IDLE;
			round_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				xorwow_pkg::ST_IDLE: begin
					round_q <= 1'b0;
					idx_q   <= '0;
				end
				xorwow_pkg::ST_MIX:   round_q <= 1'b1;
				xorwow_pkg::ST_STORE: begin
					round_q <= 1'b0;
					idx_q   <= idx_q + 1'b1;
				end
				default: ;
			endcase
			if (accept && (in_op == xorwow_pkg::OP_GENERATE))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/xorwow_dp.sv */
// Datapath of the xorwow generator: state words, Weyl counter, settings,
// the xorshift step and the seed finaliser on one shared 32x32 multiplier.
// Depends on xorwow_pkg; commanded by xorwow_ctrl.
module xorwow_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  xorwow_pkg::dp_cmd_t                 cmd,
	output xorwow_pkg::dp_status_t              status,
	input  logic [31:0]                         seed,
	input  logic                                cfg_we,
	input  logic [xorwow_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [31:0]                         cfg_wdata,
	output logic [31:0]                         result
);

	logic [31:0] words_q [xorwow_pkg::NUM_WORDS];
	logic [31:0] ctr_q;
	logic [4:0]  shift_first_q, shift_second_q, shift_third_q;
	logic [31:0] weyl_inc_q;
	logic [31:0] seed_q;
	logic [63:0] x_q, acc_q;
	logic        any_q;
	logic [31:0] out_q;

	logic [31:0] t1, t2, v1, v_new, ctr_next;
	logic [63:0] load_t, mix_const;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_prod;
	logic [31:0] hash_word;

	assign status.seed_zero = (seed == 32'd0);
	assign result           = out_q;

	// Xorshift step and Weyl sum
	assign t1       = words_q[0] ^ (words_q[0] >> shift_first_q);
	assign t2       = t1 ^ (t1 << shift_second_q);
	assign v1       = words_q[xorwow_pkg::NUM_WORDS-1]
	                  ^ (words_q[xorwow_pkg::NUM_WORDS-1] << shift_third_q);
	assign v_new    = v1 ^ t2;
	assign ctr_next = ctr_q + weyl_inc_q;

	// Finaliser operands
	assign load_t    = {32'd0, seed_q} ^ xorwow_pkg::seed_mask(cmd.word_idx);
	assign mix_const = cmd.round ? xorwow_pkg::MIX_MUL_B : xorwow_pkg::MIX_MUL_A;
	assign hash_word = acc_q[31:0] ^ acc_q[62:31];

	// Select the partial product of this step
	always_comb begin
		mul_a = x_q[31:0];
		mul_b = mix_const[31:0];
		case (cmd.op)
			xorwow_pkg::DP_MUL_HL: begin
				mul_a = x_q[63:32];
				mul_b = mix_const[31:0];
			end
			xorwow_pkg::DP_MUL_LH: begin
				mul_a = x_q[31:0];
				mul_b = mix_const[63:32];
			end
			default: ;
		endcase
	end

	assign mul_prod = 64'(mul_a) * 64'(mul_b);

	// Settings, state words and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_first_q  <= xorwow_pkg::RST_SHIFT_FIRST;
			shift_second_q <= xorwow_pkg::RST_SHIFT_SECOND;
			shift_third_q  <= xorwow_pkg::RST_SHIFT_THIRD;
			weyl_inc_q     <= xorwow_pkg::RST_WEYL_INC;
			ctr_q          <= xorwow_pkg::COUNTER_START;
			for (int i = 0; i < xorwow_pkg::NUM_WORDS; i++)
				words_q[i] <= xorwow_pkg::default_word(xorwow_pkg::IDX_W'(i));
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					xorwow_pkg::REG_SHIFT_FIRST:  shift_first_q  <= cfg_wdata[4:0];
					xorwow_pkg::REG_SHIFT_SECOND: shift_second_q <= cfg_wdata[4:0];
					xorwow_pkg::REG_SHIFT_THIRD:  shift_third_q  <= cfg_wdata[4:0];
					xorwow_pkg::REG_WEYL_INC:     weyl_inc_q     <= cfg_wdata;
					default: ;
				endcase
			end
			case (cmd.op)
				xorwow_pkg::DP_GEN: begin
					for (int i = 0; i < xorwow_pkg::NUM_WORDS - 1; i++)
						words_q[i] <= words_q[i+1];
					words_q[xorwow_pkg::NUM_WORDS-1] <= v_new;
					ctr_q <= ctr_next;
				end
				xorwow_pkg::DP_DEFAULT: begin
					for (int i = 0; i < xorwow_pkg::NUM_WORDS; i++)
						words_q[i] <= xorwow_pkg::default_word(xorwow_pkg::IDX_W'(i));
					ctr_q <= xorwow_pkg::COUNTER_START;
				end
				xorwow_pkg::DP_SEED: ctr_q <= xorwow_pkg::COUNTER_START;
				xorwow_pkg::DP_STORE: begin
					// hashed words enter at the top, so word 0 lands lowest
					for (int i = 0; i < xorwow_pkg::NUM_WORDS - 1; i++)
						words_q[i] <= words_q[i+1];
					words_q[xorwow_pkg::NUM_WORDS-1] <= hash_word;
				end
				xorwow_pkg::DP_FIX: begin
					if (!any_q)
						words_q[0] <= 32'd1;
				end
				default: ;
			endcase
		end
	end

	// Non-zero tracking over the hashed words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else begin
			case (cmd.op)
				xorwow_pkg::DP_SEED:  any_q <= 1'b0;
				xorwow_pkg::DP_STORE: any_q <= any_q | (hash_word != 32'd0);
				default: ;
			endcase
		end
	end

	// Finaliser working registers and output data
	always_ff @(posedge clk) begin
		case (cmd.op)
			xorwow_pkg::DP_GEN:    out_q  <= ctr_next + v_new;
			xorwow_pkg::DP_SEED:   seed_q <= seed;
			xorwow_pkg::DP_LOAD:   x_q    <= load_t ^ (load_t >> 30);
			xorwow_pkg::DP_MUL_LL: acc_q  <= mul_prod;
			xorwow_pkg::DP_MUL_HL,
			xorwow_pkg::DP_MUL_LH: acc_q[63:32] <= acc_q[63:32] + mul_prod[31:0];
			xorwow_pkg::DP_MIX:    x_q    <= acc_q ^ (acc_q >> 27);
			default: ;
		endcase
	end

endmodule

/* rtl/core/xorwow_random_generator.sv */
// Xorwow generator top level. A generate's number sits in the output register the cycle
// after the transfer; one generate per cycle is accepted while the output is not stalled.
// A reseed with a non-zero seed holds the input off while each of the five words runs through
// load, three partial products on the shared 32x32 multiplier, mix, three more and store,
// then through the all-zero check. A zero seed restores the default words at its transfer.
// Reset restores the default words, counter and settings.
`include "assert_macros.svh"

module xorwow_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] random_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	xorwow_pkg::dp_cmd_t    cmd;
	xorwow_pkg::dp_status_t status;
	logic                   gen_xfer, reseed_xfer;

	// Settings are always writable
	assign cfg_ready = 1'b1;

	xorwow_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	xorwow_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.seed      (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.result    (m_axis_tdata)
	);

	assign gen_xfer    = s_axis_tvalid && s_axis_tready
	                     && (s_axis_tuser == xorwow_pkg::OP_GENERATE);
	assign reseed_xfer = s_axis_tvalid && s_axis_tready
	                     && (s_axis_tuser == xorwow_pkg::OP_RESEED);

	`ASSERT_IMPLIES(a_gen_has_room, gen_xfer, !m_axis_tvalid || m_axis_tready, "generate taken with output full")
	`ASSERT_NEXT(a_gen_gives_result, gen_xfer, m_axis_tvalid, "generate gave no result")
	`ASSERT_NEXT(a_reseed_silent, reseed_xfer && !m_axis_tvalid, !m_axis_tvalid, "reseed gave a result")
	`ASSERT_NEXT(a_reseed_busy, reseed_xfer && (s_axis_tdata != 32'd0), !s_axis_tready, "input open during reseed")

endmodule

/* sim/tb_xorwow_random_generator.sv */
// Self-checking testbench for the xorwow generator: a directed table, then random phases.
// Each phase runs under its own register settings. A behavioural model predicts every number not typed in the table.
// Depends on xorwow_pkg and the xorwow_random_generator top level.
module tb_xorwow_random_generator;

	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 320;
	localparam int SETTLE_CYCLES    = 60;     // covers a non-zero reseed with margin
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int TIMEOUT_UNITS    = 8_000_000;

	localparam logic [31:0] SEED_COUNTER = 32'd6615241;
	localparam logic [63:0] HASH_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] HASH_MUL_B   = 64'h94d049bb133111eb;
	localparam logic [0:4][31:0] BOOT_WORDS = {
		32'd123456789, 32'd362436069, 32'd521288629, 32'd88675123, 32'd5783321
	};
	localparam logic [0:4][63:0] SEED_MASKS = {
		64'h0000000000000000, 64'h5555555555555555, 64'h0AAAAAAAAAAAAAAA,
		64'h0123456789ABCDEF, 64'h0FEDCBA987654321
	};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [1:0]  reg_sel;
		logic [31:0] value;    // seed for items, write data for registers
		logic        typed;    // expected number given below rather than predicted
		logic [31:0] want;
	} dir_row_t;

	// Zero shifts clear both mixed words, so the number is the bare Weyl counter
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'hFFFFFFFF, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_RESEED,   xorwow_pkg::REG_SHIFT_FIRST,
			32'hFFFFFFFF, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_RESEED,   xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000001, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_RESEED,   xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_SECOND,
			32'h0000001F, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_THIRD,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_WEYL_INC,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_RESEED,   xorwow_pkg::REG_SHIFT_FIRST,
			32'h80000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b1, 32'd6615241},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b1, 32'd6615241},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_WEYL_INC,
			32'hFFFFFFFF, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_RESEED,   xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b1, 32'd6615240},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b1, 32'd6615239},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h0000001F, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_SECOND,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_CFG,  xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_THIRD,
			32'h0000001F, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0},
		'{ROW_ITEM, xorwow_pkg::OP_GENERATE, xorwow_pkg::REG_SHIFT_FIRST,
			32'h00000000, 1'b0, 32'd0}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = 32'd0;
	logic        s_axis_tuser  = xorwow_pkg::OP_GENERATE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = xorwow_pkg::REG_SHIFT_FIRST;
	logic [31:0] cfg_data      = 32'd0;

	// Generator model state and its copy of the registers
	logic [31:0] mdl_words [5];
	logic [31:0] mdl_counter;
	logic [4:0]  mdl_shift_first, mdl_shift_second, mdl_shift_third;
	logic [31:0] mdl_weyl_inc;

	logic [31:0] pending_numbers [$];
	int          errors        = 0;
	bit          sink_hold_req = 1'b0;

	xorwow_random_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// 64-bit finaliser folded down to the low word
	function automatic logic [31:0] splitmix_fold(input logic [63:0] x);
		logic [63:0] y;
		y = (x ^ (x >> 30)) * HASH_MUL_A;
		y = (y ^ (y >> 27)) * HASH_MUL_B;
		y = y ^ (y >> 31);
		return y[31:0];
	endfunction

	// Pause length: mostly short, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	task automatic model_reseed(input logic [31:0] seed);
		bit any_set;
		any_set = 1'b0;
		if (seed == 32'd0) begin
			for (int i = 0; i < 5; i++)
				mdl_words[i] = BOOT_WORDS[i];
		end else begin
			for (int i = 0; i < 5; i++) begin
				mdl_words[i] = splitmix_fold({32'd0, seed} ^ SEED_MASKS[i]);
				if (mdl_words[i] != 32'd0)
					any_set = 1'b1;
			end
			// an all-zero state would lock up, so force the oldest word
			if (!any_set)
				mdl_words[0] = 32'd1;
		end
		mdl_counter = SEED_COUNTER;
	endtask

	task automatic model_generate(output logic [31:0] number);
		logic [31:0] t, v;
		t = mdl_words[0];
		v = mdl_words[4];
		t = t ^ (t >> mdl_shift_first);
		t = t ^ (t << mdl_shift_second);
		v = v ^ (v << mdl_shift_third);
		v = v ^ t;
		for (int i = 0; i < 4; i++)
			mdl_words[i] = mdl_words[i + 1];
		mdl_words[4] = v;
		mdl_counter  = mdl_counter + mdl_weyl_inc;
		number       = mdl_counter + v;
	endtask

	// Offer one item, hold it until the transfer, then advance the model
	task automatic offer_item(input logic op, input logic [31:0] seed,
		input bit typed, input logic [31:0] want);
		logic [31:0] number;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= seed;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		if (op == xorwow_pkg::OP_RESEED) begin
			model_reseed(seed);
		end else begin
			model_generate(number);
			pending_numbers.push_back(typed ? want : number);
		end
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			xorwow_pkg::REG_SHIFT_FIRST:  mdl_shift_first  = value[4:0];
			xorwow_pkg::REG_SHIFT_SECOND: mdl_shift_second = value[4:0];
			xorwow_pkg::REG_SHIFT_THIRD:  mdl_shift_third  = value[4:0];
			xorwow_pkg::REG_WEYL_INC:     mdl_weyl_inc     = value;
			default: ;
		endcase
	endtask

	// Stop offering and wait for every outstanding number; optionally let a reseed finish
	task automatic wait_idle(input bit settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_numbers.size() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Check each number transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_numbers.size() == 0) begin
				$error("random_value: none expected, actual %h", m_axis_tdata);
				errors++;
			end else if (m_axis_tdata !== pending_numbers[0]) begin
				$error("random_value: expected %h, actual %h", pending_numbers[0], m_axis_tdata);
				errors++;
				void'(pending_numbers.pop_front());
			end else begin
				void'(pending_numbers.pop_front());
			end
		end
	end

	// Receiver: calm and choppy stretches, plus one long hold on request
	initial begin : sink
		int  stall_left;
		int  mode_left;
		bit  calm;
		stall_left = 0;
		mode_left  = 0;
		calm       = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				calm      = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 200);
			end
			mode_left--;
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = pause_len() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus: reset, directed table, random phases, then the verdict
	initial begin : stimulus
		bit          in_cfg;
		bit          busy;
		int          gap;
		int          seed_kind;
		logic        op;
		logic [31:0] seed;
		logic [31:0] cfg_vals [4];

		mdl_shift_first  = 5'd2;
		mdl_shift_second = 5'd1;
		mdl_shift_third  = 5'd4;
		mdl_weyl_inc     = 32'd362437;
		for (int i = 0; i < 5; i++)
			mdl_words[i] = BOOT_WORDS[i];
		mdl_counter = SEED_COUNTER;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		in_cfg = 1'b0;
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				if (!in_cfg)
					wait_idle(1'b1);
				in_cfg = 1'b1;
				write_reg(DIRECTED[r].reg_sel, DIRECTED[r].value);
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				offer_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed,
					DIRECTED[r].want);
			end
		end

		// Random phases, each under fresh register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: cfg_vals = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
				1: cfg_vals = '{$urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom};
				5: cfg_vals = '{32'd2, 32'd1, 32'd4, 32'd362437};
				default: cfg_vals = '{$urandom, $urandom, $urandom, $urandom};
			endcase
			wait_idle(1'b1);
			write_reg(xorwow_pkg::REG_SHIFT_FIRST,  cfg_vals[0]);
			write_reg(xorwow_pkg::REG_SHIFT_SECOND, cfg_vals[1]);
			write_reg(xorwow_pkg::REG_SHIFT_THIRD,  cfg_vals[2]);
			write_reg(xorwow_pkg::REG_WEYL_INC,     cfg_vals[3]);
			cfg_valid <= 1'b0;

			// hold the receiver off while generates keep coming, so the block backs up
			if (p == 3)
				sink_hold_req = 1'b1;

			busy = 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 50 == 0)
					busy = ($urandom_range(0, 2) == 0);
				if (n == ITEMS_PER_PHASE / 2)
					wait_idle(1'b0);

				seed_kind = $urandom_range(0, 9);
				case (seed_kind)
					0:       seed = 32'd0;
					1:       seed = 32'hFFFFFFFF;
					2:       seed = 32'd1 << $urandom_range(0, 31);
					default: seed = $urandom;
				endcase
				op = ($urandom_range(0, 11) == 0) ? xorwow_pkg::OP_RESEED
					: xorwow_pkg::OP_GENERATE;
				if (p == 3 && n < 60)
					op = xorwow_pkg::OP_GENERATE;

				gap = (busy || (p == 3 && n < 60) || $urandom_range(0, 1) == 0) ? 0 : pause_len();
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				offer_item(op, seed, 1'b0, 32'd0);
			end
		end

		wait_idle(1'b1);
		if (errors == 0 && pending_numbers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#(TIMEOUT_UNITS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
